>>> design/quadrature_detent_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// Quadrature detent decoder assertion macros
// Shared concurrent assertion forms, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DETENT_DECODER_CORE_DEFINES_SVH
`define QUADRATURE_DETENT_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define QDD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/qdd_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature detent decoder package
// Beat types, register indexes and the quadrature transition table.
// ----------------------------------------------------------------------------
package qdd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_CLEAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEGATE     = 2'd1;

    localparam logic [15:0] IDLE_CLEAR_RESET = 16'd3000;

    localparam logic REQ_SCAN = 1'b0;
    localparam logic REQ_READ = 1'b1;

    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_MIN = 16'sh8000;

    typedef struct packed {
        logic req_type;
        logic pin_a;
        logic pin_b;
    } t_item;

    typedef struct packed {
        logic signed [2:0]  sub_steps;
        logic signed [1:0]  detent_step;
        logic signed [15:0] detent_count;
    } t_result;

    typedef struct packed {
        logic [15:0] idle_clear_scans;
        logic        negate_direction;
    } t_cfg;

    // index = {prev A, prev B, cur A, cur B}
    localparam logic signed [1:0] STEP_TABLE [16] = '{
         2'sd0,  2'sd1, -2'sd1,  2'sd0,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
         2'sd0, -2'sd1,  2'sd1,  2'sd0
    };

endpackage

>>> design/qdd_in_reg.sv
// ----------------------------------------------------------------------------
// Quadrature detent decoder input register
// Holds one request beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module qdd_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [7:0]     s_axis_tdata,   // [0] pin_a, [1] pin_b, [7:2] zero
    input  logic           s_axis_tuser,   // [0] req_type
    input  logic           i_take,
    output logic           o_valid,
    output qdd_pkg::t_item o_item
);
    import qdd_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign s_axis_tready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_item        = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.req_type <= s_axis_tuser;
            r_item.pin_a    <= s_axis_tdata[0];
            r_item.pin_b    <= s_axis_tdata[1];
        end
    end

endmodule

>>> design/qdd_decode.sv
// ----------------------------------------------------------------------------
// Quadrature detent decoder state and decode
// Transition lookup, sub-step and detent accumulation, idle residue clear, read-and-clear.
// ----------------------------------------------------------------------------
`include "quadrature_detent_decoder_core_defines.svh"

module qdd_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  qdd_pkg::t_item   i_item,
    input  qdd_pkg::t_cfg    i_cfg,
    output qdd_pkg::t_result o_result
);
    import qdd_pkg::*;

    logic [1:0]         r_prev;
    logic [1:0]         n_prev;
    logic               r_primed;
    logic               n_primed;
    logic signed [2:0]  r_sub;
    logic signed [2:0]  n_sub;
    logic signed [15:0] r_detent;
    logic signed [15:0] n_detent;
    logic [15:0]        r_idle;
    logic [15:0]        n_idle;

    logic [1:0]         cur;
    logic signed [1:0]  q;
    logic signed [3:0]  sum;
    logic [15:0]        idle_inc;
    logic signed [15:0] read_val;

    assign cur = {i_item.pin_a, i_item.pin_b};
    assign q   = STEP_TABLE[{r_prev, cur}];
    assign sum = {r_sub[2], r_sub} + {{2{q[1]}}, q};
    assign idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;

    always_comb begin
        if (!i_cfg.negate_direction) begin
            read_val = r_detent;
        end else if (r_detent == COUNT_MIN) begin
            read_val = COUNT_MAX;
        end else begin
            read_val = -r_detent;
        end
    end

    always_comb begin
        n_prev   = r_prev;
        n_primed = r_primed;
        n_sub    = r_sub;
        n_detent = r_detent;
        n_idle   = r_idle;
        o_result.detent_count = '0;
        o_result.detent_step  = '0;
        if (i_item.req_type == REQ_READ) begin
            o_result.detent_count = read_val;
            n_detent = '0;
        end else if (!r_primed) begin
            n_primed = 1'b1;
            n_prev   = cur;
        end else begin
            n_prev = cur;
            n_sub  = sum[2:0];
            if (sum == 4'sd4) begin
                n_sub = '0;
                o_result.detent_step = 2'sd1;
                if (r_detent != COUNT_MAX) begin
                    n_detent = r_detent + 16'sd1;
                end
            end else if (sum == -4'sd4) begin
                n_sub = '0;
                o_result.detent_step = -2'sd1;
                if (r_detent != COUNT_MIN) begin
                    n_detent = r_detent - 16'sd1;
                end
            end
            if (q != 2'sd0) begin
                n_idle = '0;
            end else if (n_sub != 3'sd0) begin
                if (idle_inc >= i_cfg.idle_clear_scans) begin
                    n_sub  = '0;
                    n_idle = '0;
                end else begin
                    n_idle = idle_inc;
                end
            end
        end
        o_result.sub_steps = n_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_primed <= 1'b0;
            r_sub    <= '0;
            r_detent <= '0;
            r_idle   <= '0;
        end else if (i_fire) begin
            r_prev   <= n_prev;
            r_primed <= n_primed;
            r_sub    <= n_sub;
            r_detent <= n_detent;
            r_idle   <= n_idle;
        end
    end

    `QDD_ASSERT_NOW(a_sub_range, i_clk, i_rst_n, 1'b1, r_sub != 3'b100, "residue out of range")
    `QDD_ASSERT_NOW(a_unprimed_clean, i_clk, i_rst_n, !r_primed, (r_sub == 3'sd0) && (r_idle == 16'd0), "state moved before priming")
    `QDD_ASSERT_NEXT(a_read_clears, i_clk, i_rst_n, i_fire && (i_item.req_type == REQ_READ), r_detent == 16'sd0, "read did not clear count")
    `QDD_ASSERT_NEXT(a_read_keeps_sub, i_clk, i_rst_n, i_fire && (i_item.req_type == REQ_READ), $stable(r_sub) && $stable(r_idle), "read touched residue")

endmodule

>>> design/quadrature_detent_decoder_core.sv
// ----------------------------------------------------------------------------
// Quadrature detent decoder core
// x4 quadrature decode into detents, with read-and-clear of the detent count.
//
//   channel | direction | beat contents
//   s_axis  | in        | tuser req_type, tdata {pin_b, pin_a}
//   m_axis  | out       | tdata {sub_steps, detent_step, detent_count}
//   cfg     | in        | index, 16-bit data, always ready
//
// One beat per cycle sustained while m_axis does not stall; each beat passes the
// input register, then decode into the result register.
// A result waits in the output register while the next beat sits in the
// input register; a stall on m_axis backs up to s_axis through that register.
// Reset (synchronous, active low) clears handshake state, decoder state and
// the registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
`include "quadrature_detent_decoder_core_defines.svh"

module quadrature_detent_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_a, [1] pin_b, [7:2] zero
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] detent_count, [17:16] detent_step,
                                        // [20:18] sub_steps, [23:21] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import qdd_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    take;
    t_result result;
    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    assign take = item_valid && (!r_out_valid || m_axis_tready);

    qdd_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (take),
        .o_valid       (item_valid),
        .o_item        (item)
    );

    qdd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_clear_scans <= IDLE_CLEAR_RESET;
            r_cfg.negate_direction <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_IDLE_CLEAR) begin
                r_cfg.idle_clear_scans <= i_cfg_data;
            end
            if (i_cfg_index == REG_NEGATE) begin
                r_cfg.negate_direction <= i_cfg_data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

    `QDD_ASSERT_NEXT(a_take_loads_out, i_clk, i_rst_n, take, r_out_valid, "taken beat lost")
    `QDD_ASSERT_NOW(a_stall_no_take, i_clk, i_rst_n, r_out_valid && !m_axis_tready, !take, "decode ran over a held result")

endmodule
